// File: design/sgrp_pkg.sv
package sgrp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SOCKS_VER    = 8'd5;
  localparam logic [7:0] METHOD_NONE  = 8'd0;
  localparam logic [7:0] NO_METHOD    = 8'd255;
  localparam logic [7:0] REPLY_OK     = 8'd0;
  localparam logic [7:0] ATYP_IPV4    = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN  = 8'd3;
  localparam logic [7:0] ATYP_IPV6    = 8'd4;
  localparam logic [7:0] CMD_CONNECT  = 8'd1;
  localparam logic [8:0] IPV4_LEN     = 9'd4;
  localparam logic [8:0] IPV6_LEN     = 9'd16;

  typedef enum logic [3:0] {
    PH_GVER,
    PH_NMETH,
    PH_METH,
    PH_RVER,
    PH_RCMD,
    PH_RRSV,
    PH_RATYP,
    PH_DLEN,
    PH_ADDR,
    PH_PHI,
    PH_PLO,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_GREET_VER,
    ERR_ATYP,
    ERR_REQ_VER,
    ERR_CMD
  } err_t;

  typedef enum logic [1:0] {
    KIND_IPV4,
    KIND_DOMAIN,
    KIND_IPV6
  } kind_t;

  // One queue entry: every reply beat caused by one client byte.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    err_t            err;
    logic            done;
    kind_t           kind;
    logic [15:0]     port;
  } grp_t;

endpackage

// File: design/sgrp_in_if.sv
interface sgrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] client_byte;

  modport source (output valid, output client_byte, input ready);
  modport sink (input valid, input client_byte, output ready);
endinterface

// File: design/sgrp_out_if.sv
interface sgrp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_byte;
  logic        last_of_run;
  logic [2:0]  error_code;
  logic        request_done;
  logic [1:0]  address_kind;
  logic [15:0] port_bytes;

  modport source (
    output valid, output reply_byte, output last_of_run, output error_code,
    output request_done, output address_kind, output port_bytes, input ready
  );
  modport sink (
    input valid, input reply_byte, input last_of_run, input error_code,
    input request_done, input address_kind, input port_bytes, output ready
  );
endinterface

// File: design/socks5_greeting_request_parser.sv
// channel | dir | payload
// client  | in  | client_byte
// reply   | out | reply_byte, last_of_run, error_code, request_done,
//         |     | address_kind, port_bytes
//
// A client byte is taken every cycle while the reply queue has room; it is
// parsed in the cycle after and its 0 to 4 reply beats are queued as one entry.
// Replies leave at one beat per cycle while reply ready is high, and the
// DEPTH-entry queue absorbs bursts. rst (synchronous) returns the parser to
// the greeting and empties the queue. A stalled reply side fills the queue
// and then drops client ready.
module socks5_greeting_request_parser #(
  parameter int DEPTH = sgrp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  sgrp_in_if.sink    client,
  sgrp_out_if.source reply
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // parser state
  sgrp_pkg::phase_t phase, phase_next;
  logic [7:0]       methods_left, methods_left_next;
  logic             no_auth_seen, no_auth_seen_next;
  logic [23:0]      header_bytes, header_bytes_next;
  logic [8:0]       address_left, address_left_next;
  sgrp_pkg::kind_t  kind_held, kind_held_next;
  logic [7:0]       port_high_held, port_high_held_next;
  logic             error_latched, error_latched_next;

  // result of the current byte
  logic           push;
  sgrp_pkg::grp_t grp;

  // reply queue
  sgrp_pkg::grp_t   queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       sub;
  logic             pop, beat_out, is_last;
  logic [CNT_W-1:0] occupancy;
  sgrp_pkg::grp_t   head;

  assign occupancy    = count + CNT_W'(in_valid_q);
  assign client.ready = occupancy < CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= client.valid && client.ready;
    end
    if (client.valid && client.ready) begin
      in_byte_q <= client.client_byte;
    end
  end

  // next-state logic
  always_comb begin
    logic [7:0] b;
    logic [7:0] ml_dec;
    logic [8:0] al_dec;
    b                   = in_byte_q;
    ml_dec              = methods_left - 8'd1;
    al_dec              = address_left - 9'd1;
    phase_next          = phase;
    methods_left_next   = methods_left;
    no_auth_seen_next   = no_auth_seen;
    header_bytes_next   = header_bytes;
    address_left_next   = address_left;
    kind_held_next      = kind_held;
    port_high_held_next = port_high_held;
    error_latched_next  = error_latched;
    if (in_valid_q && !error_latched) begin
      unique case (phase)
        sgrp_pkg::PH_GVER: begin
          if (b != sgrp_pkg::SOCKS_VER) error_latched_next = 1'b1;
          else phase_next = sgrp_pkg::PH_NMETH;
        end
        sgrp_pkg::PH_NMETH: begin
          methods_left_next = b;
          no_auth_seen_next = 1'b0;
          phase_next = (b == 8'd0) ? sgrp_pkg::PH_RVER : sgrp_pkg::PH_METH;
        end
        sgrp_pkg::PH_METH: begin
          if (b == sgrp_pkg::METHOD_NONE) no_auth_seen_next = 1'b1;
          methods_left_next = ml_dec;
          if (ml_dec == 8'd0) phase_next = sgrp_pkg::PH_RVER;
        end
        sgrp_pkg::PH_RVER: begin
          header_bytes_next = {b, 16'd0};
          phase_next = sgrp_pkg::PH_RCMD;
        end
        sgrp_pkg::PH_RCMD: begin
          header_bytes_next = {header_bytes[23:16], b, 8'd0};
          phase_next = sgrp_pkg::PH_RRSV;
        end
        sgrp_pkg::PH_RRSV: begin
          header_bytes_next = {header_bytes[23:8], b};
          phase_next = sgrp_pkg::PH_RATYP;
        end
        sgrp_pkg::PH_RATYP: begin
          if (b == sgrp_pkg::ATYP_IPV4) begin
            kind_held_next    = sgrp_pkg::KIND_IPV4;
            address_left_next = sgrp_pkg::IPV4_LEN;
            phase_next        = sgrp_pkg::PH_ADDR;
          end else if (b == sgrp_pkg::ATYP_DOMAIN) begin
            kind_held_next    = sgrp_pkg::KIND_DOMAIN;
            address_left_next = 9'd0;
            phase_next        = sgrp_pkg::PH_DLEN;
          end else if (b == sgrp_pkg::ATYP_IPV6) begin
            kind_held_next    = sgrp_pkg::KIND_IPV6;
            address_left_next = sgrp_pkg::IPV6_LEN;
            phase_next        = sgrp_pkg::PH_ADDR;
          end
          if ((b != sgrp_pkg::ATYP_IPV4 && b != sgrp_pkg::ATYP_DOMAIN &&
               b != sgrp_pkg::ATYP_IPV6) ||
              header_bytes[23:16] != sgrp_pkg::SOCKS_VER ||
              header_bytes[15:8] != sgrp_pkg::CMD_CONNECT) begin
            error_latched_next = 1'b1;
          end
        end
        sgrp_pkg::PH_DLEN: begin
          address_left_next = {1'b0, b};
          phase_next = (b == 8'd0) ? sgrp_pkg::PH_PHI : sgrp_pkg::PH_ADDR;
        end
        sgrp_pkg::PH_ADDR: begin
          address_left_next = al_dec;
          if (al_dec == 9'd0) phase_next = sgrp_pkg::PH_PHI;
        end
        sgrp_pkg::PH_PHI: begin
          port_high_held_next = b;
          phase_next = sgrp_pkg::PH_PLO;
        end
        sgrp_pkg::PH_PLO: begin
          phase_next = sgrp_pkg::PH_DONE;
        end
        sgrp_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // reply beats for the current byte
  always_comb begin
    logic [7:0] b;
    logic       no_auth_upd;
    b           = in_byte_q;
    no_auth_upd = no_auth_seen || (b == sgrp_pkg::METHOD_NONE);
    push        = 1'b0;
    grp         = '0;
    if (in_valid_q && !error_latched) begin
      unique case (phase)
        sgrp_pkg::PH_GVER: begin
          if (b != sgrp_pkg::SOCKS_VER) begin
            push    = 1'b1;
            grp.err = sgrp_pkg::ERR_GREET_VER;
          end
        end
        sgrp_pkg::PH_NMETH: begin
          if (b == 8'd0) begin
            push         = 1'b1;
            grp.bytes[0] = sgrp_pkg::SOCKS_VER;
            grp.bytes[1] = sgrp_pkg::NO_METHOD;
            grp.last_idx = 2'd1;
          end
        end
        sgrp_pkg::PH_METH: begin
          if (methods_left == 8'd1) begin
            push         = 1'b1;
            grp.bytes[0] = sgrp_pkg::SOCKS_VER;
            grp.bytes[1] = no_auth_upd ? sgrp_pkg::METHOD_NONE : sgrp_pkg::NO_METHOD;
            grp.last_idx = 2'd1;
          end
        end
        sgrp_pkg::PH_RVER, sgrp_pkg::PH_RCMD, sgrp_pkg::PH_RRSV: begin
        end
        sgrp_pkg::PH_RATYP: begin
          push = 1'b1;
          // fault priority: address type, then version, then command
          if (b != sgrp_pkg::ATYP_IPV4 && b != sgrp_pkg::ATYP_DOMAIN &&
              b != sgrp_pkg::ATYP_IPV6) begin
            grp.err = sgrp_pkg::ERR_ATYP;
          end else if (header_bytes[23:16] != sgrp_pkg::SOCKS_VER) begin
            grp.err = sgrp_pkg::ERR_REQ_VER;
          end else if (header_bytes[15:8] != sgrp_pkg::CMD_CONNECT) begin
            grp.err = sgrp_pkg::ERR_CMD;
          end else begin
            grp.bytes[0] = sgrp_pkg::SOCKS_VER;
            grp.bytes[1] = sgrp_pkg::REPLY_OK;
            grp.bytes[2] = header_bytes[7:0];
            grp.bytes[3] = b;
            grp.last_idx = 2'd3;
          end
        end
        sgrp_pkg::PH_DLEN, sgrp_pkg::PH_ADDR, sgrp_pkg::PH_PHI: begin
          push         = 1'b1;
          grp.bytes[0] = b;
        end
        sgrp_pkg::PH_PLO: begin
          push         = 1'b1;
          grp.bytes[0] = b;
          grp.done     = 1'b1;
          grp.kind     = kind_held;
          grp.port     = {port_high_held, b};
        end
        sgrp_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sgrp_pkg::PH_GVER;
      methods_left   <= '0;
      no_auth_seen   <= 1'b0;
      header_bytes   <= '0;
      address_left   <= '0;
      kind_held      <= sgrp_pkg::KIND_IPV4;
      port_high_held <= '0;
      error_latched  <= 1'b0;
    end else begin
      phase          <= phase_next;
      methods_left   <= methods_left_next;
      no_auth_seen   <= no_auth_seen_next;
      header_bytes   <= header_bytes_next;
      address_left   <= address_left_next;
      kind_held      <= kind_held_next;
      port_high_held <= port_high_held_next;
      error_latched  <= error_latched_next;
    end
  end

  // reply queue: at most one entry per client byte, drained a beat at a time
  assign head     = queue[rd_ptr];
  assign beat_out = reply.valid && reply.ready;
  assign is_last  = sub == head.last_idx;
  assign pop      = beat_out && is_last;

  assign reply.valid        = count != '0;
  assign reply.reply_byte   = head.bytes[sub];
  assign reply.last_of_run  = is_last;
  assign reply.error_code   = head.err;
  assign reply.request_done = head.done;
  assign reply.address_kind = head.kind;
  assign reply.port_bytes   = head.port;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= grp;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
      if (beat_out) begin
        sub <= is_last ? 2'd0 : sub + 2'd1;
      end
    end
  end

endmodule
